/* rtl/rtc_calendar_to_epoch_seconds_core_defines.svh */
// Assertion macros shared by the RTC-to-epoch checker.
`ifndef RTC_CALENDAR_TO_EPOCH_SECONDS_CORE_DEFINES_SVH
`define RTC_CALENDAR_TO_EPOCH_SECONDS_CORE_DEFINES_SVH

// Property checked outside reset.
`define RCTE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Property checked at every edge, reset included.
`define RCTE_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/rcte_pkg.sv */
// Package: shared types and constants for the RTC-to-epoch converter.
`timescale 1ns / 1ps
package rcte_pkg;

  localparam int RAW_W      = 8;
  localparam int MONTH_W    = 4;
  localparam int DAYS_W     = 17;
  localparam int HMS_W      = 20;
  localparam int EPOCH_W    = 34;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

  // accept edge to the edge that takes done: front reg, queue, three back stages
  localparam int PIPE_LAT   = 5;

  localparam int PM_BIT        = 7;
  localparam int YEAR_PIVOT    = 70;
  localparam int CENTURY_19    = 1900;
  localparam int CENTURY_20    = 2000;
  localparam int EPOCH_YEAR    = 1970;
  // 2100 is the only century year in range that is not a leap year
  localparam int NOLEAP_OFF    = 2100 - EPOCH_YEAR;
  localparam int DAYS_PER_YEAR = 365;
  localparam int SECS_PER_DAY  = 86400;
  localparam int SECS_PER_HOUR = 3600;
  localparam int SECS_PER_MIN  = 60;
  localparam int HOURS_PER_DAY = 24;

  typedef struct packed {
    logic [RAW_W-1:0]   sec;
    logic [RAW_W-1:0]   min;
    logic [RAW_W-1:0]   hour;
    logic [RAW_W-1:0]   day_idx;   // day of month minus one, zero kept
    logic [MONTH_W-1:0] month;     // clamped to 1..12
    logic [RAW_W-1:0]   year_off;  // years since 1970
  } dec_t;

  typedef struct packed {
    logic valid;
    dec_t data;
  } xfer_t;

endpackage

/* rtl/rcte_front.sv */
// Front end: accepts a snapshot, decodes BCD and hour modes, normalizes fields.
`timescale 1ns / 1ps
module rcte_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  logic [7:0]            sec_raw,
  input  logic [7:0]            min_raw,
  input  logic [7:0]            hour_raw,
  input  logic [7:0]            day_raw,
  input  logic [7:0]            month_raw,
  input  logic [7:0]            year_raw,
  input  logic                  binary_mode,
  input  logic                  hour_24_mode,
  input  logic                  full,
  output rcte_pkg::xfer_t       push
);
  import rcte_pkg::*;

  logic                 valid;
  dec_t                 dec;
  dec_t                 dec_next;
  logic                 accept;
  logic [RAW_W-1:0]     sec_d, min_d, hour_d, day_d, mon_d, yr_d;
  logic [RAW_W-1:0]     hour_lo;
  logic [RAW_W-1:0]     hour_12;
  logic [RAW_W-1:0]     hour_pm;

  function automatic logic [RAW_W-1:0] bcd_decode(input logic [RAW_W-1:0] v);
    logic [RAW_W-1:0] hi;
    hi = {4'd0, v[7:4]};
    return (hi << 3) + (hi << 1) + {4'd0, v[3:0]};
  endfunction

  // value stays below 140, so three conditional subtracts finish it
  function automatic logic [RAW_W-1:0] mod_day(input logic [RAW_W-1:0] v);
    logic [RAW_W-1:0] r;
    r = v;
    if (r >= RAW_W'(4 * HOURS_PER_DAY)) r = r - RAW_W'(4 * HOURS_PER_DAY);
    if (r >= RAW_W'(2 * HOURS_PER_DAY)) r = r - RAW_W'(2 * HOURS_PER_DAY);
    if (r >= RAW_W'(HOURS_PER_DAY)) r = r - RAW_W'(HOURS_PER_DAY);
    return r;
  endfunction

  assign accept = start && !busy;
  assign busy   = valid && full;

  always_comb begin
    sec_d   = binary_mode ? sec_raw   : bcd_decode(sec_raw);
    min_d   = binary_mode ? min_raw   : bcd_decode(min_raw);
    day_d   = binary_mode ? day_raw   : bcd_decode(day_raw);
    mon_d   = binary_mode ? month_raw : bcd_decode(month_raw);
    yr_d    = binary_mode ? year_raw  : bcd_decode(year_raw);
    // BCD hours keep the PM bit on top of the decoded low seven bits
    hour_lo = bcd_decode({1'b0, hour_raw[6:0]});
    hour_d  = binary_mode ? hour_raw : {hour_raw[PM_BIT], hour_lo[6:0]};

    hour_12 = {1'b0, hour_d[6:0]};
    if (hour_12 == RAW_W'(12)) hour_12 = '0;
    hour_pm = mod_day(hour_12 + RAW_W'(12));

    dec_next.sec = sec_d;
    dec_next.min = min_d;
    if (hour_24_mode) begin
      dec_next.hour = hour_d;
    end else if (hour_d[PM_BIT]) begin
      dec_next.hour = hour_pm;
    end else begin
      dec_next.hour = hour_12;
    end

    dec_next.day_idx = (day_d == '0) ? '0 : day_d - RAW_W'(1);

    if (mon_d == '0) begin
      dec_next.month = MONTH_W'(1);
    end else if (mon_d > RAW_W'(12)) begin
      dec_next.month = MONTH_W'(12);
    end else begin
      dec_next.month = mon_d[MONTH_W-1:0];
    end

    // below the pivot the year is 2000 plus the value, else 1900 plus the value
    if (yr_d >= RAW_W'(YEAR_PIVOT)) begin
      dec_next.year_off = yr_d - RAW_W'(EPOCH_YEAR - CENTURY_19);
    end else begin
      dec_next.year_off = yr_d + RAW_W'(CENTURY_20 - EPOCH_YEAR);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (accept) begin
      valid <= 1'b1;
    end else if (push.valid) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      dec <= dec_next;
    end
  end

  assign push.valid = valid && !full;
  assign push.data  = dec;

endmodule

/* rtl/rcte_queue.sv */
// Short queue of decoded transactions between the front and back ends.
`timescale 1ns / 1ps
module rcte_queue (
  input  logic            clk,
  input  logic            rst,
  input  rcte_pkg::xfer_t push,
  output logic            full,
  output rcte_pkg::xfer_t head,
  input  logic            pop
);
  import rcte_pkg::*;

  dec_t               entries [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr;
  logic [FIFO_AW-1:0] rd_ptr;
  logic [FIFO_CW-1:0] count;
  logic               do_push;
  logic               do_pop;

  assign full    = (count == FIFO_CW'(FIFO_DEPTH));
  assign do_push = push.valid && !full;
  assign do_pop  = pop && (count != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + FIFO_AW'(1);
      if (do_pop)  rd_ptr <= rd_ptr + FIFO_AW'(1);
      if (do_push && !do_pop) begin
        count <= count + FIFO_CW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - FIFO_CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push.data;
    end
  end

  assign head.valid = (count != '0);
  assign head.data  = entries[rd_ptr];

endmodule

/* rtl/rcte_back.sv */
// Back end: day count, scaling to seconds and final sum, three stages.
`timescale 1ns / 1ps
module rcte_back (
  input  logic                          clk,
  input  logic                          rst,
  input  rcte_pkg::xfer_t               head,
  output logic                          pop,
  output logic                          done,
  output logic [rcte_pkg::EPOCH_W-1:0]  epoch_seconds
);
  import rcte_pkg::*;

  logic                 s1_valid, s2_valid;
  logic [DAYS_W-1:0]    s1_days;
  logic [HMS_W-1:0]     s1_hms;
  logic [EPOCH_W-1:0]   s2_dsec;
  logic [HMS_W-1:0]     s2_hms;

  logic [DAYS_W-1:0]    days_next;
  logic [HMS_W-1:0]     hms_next;
  logic [DAYS_W-1:0]    leaps;
  logic                 is_leap;
  logic [RAW_W:0]       off_p1;

  function automatic logic [DAYS_W-1:0] month_start(input logic [MONTH_W-1:0] m);
    logic [DAYS_W-1:0] r;
    unique case (m)
      4'd1:    r = DAYS_W'(0);
      4'd2:    r = DAYS_W'(31);
      4'd3:    r = DAYS_W'(59);
      4'd4:    r = DAYS_W'(90);
      4'd5:    r = DAYS_W'(120);
      4'd6:    r = DAYS_W'(151);
      4'd7:    r = DAYS_W'(181);
      4'd8:    r = DAYS_W'(212);
      4'd9:    r = DAYS_W'(243);
      4'd10:   r = DAYS_W'(273);
      4'd11:   r = DAYS_W'(304);
      4'd12:   r = DAYS_W'(334);
      default: r = '0;
    endcase
    return r;
  endfunction

  // the back end never stalls: take the head whenever there is one
  assign pop = head.valid;

  always_comb begin
    // leap years from 1972 up to the year before, dropping 2100
    off_p1  = {1'b0, head.data.year_off} + (RAW_W+1)'(1);
    leaps   = DAYS_W'(off_p1 >> 2);
    if (head.data.year_off > RAW_W'(NOLEAP_OFF)) leaps = leaps - DAYS_W'(1);
    is_leap = (head.data.year_off[1:0] == 2'b10) &&
              (head.data.year_off != RAW_W'(NOLEAP_OFF));

    days_next = DAYS_W'({9'd0, head.data.year_off} * DAYS_W'(DAYS_PER_YEAR))
              + leaps
              + month_start(head.data.month)
              + DAYS_W'(is_leap && (head.data.month > MONTH_W'(2)))
              + DAYS_W'(head.data.day_idx);

    hms_next = HMS_W'({12'd0, head.data.hour} * HMS_W'(SECS_PER_HOUR))
             + HMS_W'({12'd0, head.data.min} * HMS_W'(SECS_PER_MIN))
             + HMS_W'(head.data.sec);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      done     <= 1'b0;
    end else begin
      s1_valid <= head.valid;
      s2_valid <= s1_valid;
      done     <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    s1_days       <= days_next;
    s1_hms        <= hms_next;
    s2_dsec       <= EPOCH_W'({17'd0, s1_days} * EPOCH_W'(SECS_PER_DAY));
    s2_hms        <= s1_hms;
    epoch_seconds <= s2_dsec + EPOCH_W'(s2_hms);
  end

endmodule

/* rtl/rtc_calendar_to_epoch_seconds_core.sv */
// Top level: RTC register snapshot to Unix epoch seconds.
//
//   channel   handshake          payload
//   --------  -----------------  ---------------------------------------------
//   input     start / busy       sec_raw min_raw hour_raw day_raw month_raw
//                                year_raw binary_mode hour_24_mode
//   result    done (one cycle)   epoch_seconds
//
// One snapshot per cycle while busy is low; results pass the front register,
// queue slot, day-count stage, day-scaling multiply and sum; done rises with the sum.
// The 17x17 day-to-seconds multiply sets the stage depth of the back end.
// rst is synchronous and clears all valid flags and queue pointers.
// busy rises only if the queue fills; the back end drains it every cycle.
`timescale 1ns / 1ps
module rtc_calendar_to_epoch_seconds_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [7:0]                    sec_raw,
  input  logic [7:0]                    min_raw,
  input  logic [7:0]                    hour_raw,
  input  logic [7:0]                    day_raw,
  input  logic [7:0]                    month_raw,
  input  logic [7:0]                    year_raw,
  input  logic                          binary_mode,
  input  logic                          hour_24_mode,
  output logic                          done,
  output logic [rcte_pkg::EPOCH_W-1:0]  epoch_seconds
);
  import rcte_pkg::*;

  xfer_t push;
  xfer_t head;
  logic  full;
  logic  pop;

  rcte_front u_front (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .sec_raw      (sec_raw),
    .min_raw      (min_raw),
    .hour_raw     (hour_raw),
    .day_raw      (day_raw),
    .month_raw    (month_raw),
    .year_raw     (year_raw),
    .binary_mode  (binary_mode),
    .hour_24_mode (hour_24_mode),
    .full         (full),
    .push         (push)
  );

  rcte_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .full (full),
    .head (head),
    .pop  (pop)
  );

  rcte_back u_back (
    .clk           (clk),
    .rst           (rst),
    .head          (head),
    .pop           (pop),
    .done          (done),
    .epoch_seconds (epoch_seconds)
  );

endmodule

/* rtl/rcte_checker.sv */
// Port-level checker for the RTC-to-epoch converter, bound to the top level.
`timescale 1ns / 1ps
`include "rtc_calendar_to_epoch_seconds_core_defines.svh"
module rcte_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          start,
  input logic                          busy,
  input logic                          done,
  input logic [rcte_pkg::EPOCH_W-1:0]  epoch_seconds
);
  import rcte_pkg::*;

  `RCTE_ASSERT(a_accept_gives_done, (start && !busy) |-> ##PIPE_LAT done, "transaction lost")
  `RCTE_ASSERT(a_done_has_accept, done |-> $past(start && !busy, PIPE_LAT), "result invented")
  `RCTE_ASSERT_ALWAYS(a_reset_quiet, rst |=> (!done && !busy), "activity after reset")
  `RCTE_ASSERT(a_no_busy, !busy, "queue backed up")
  `RCTE_ASSERT(a_done_known, done |-> !$isunknown(epoch_seconds), "unknown result")

endmodule

bind rtc_calendar_to_epoch_seconds_core rcte_checker u_rcte_checker (
  .clk           (clk),
  .rst           (rst),
  .start         (start),
  .busy          (busy),
  .done          (done),
  .epoch_seconds (epoch_seconds)
);
